@@ hdl/bbr_pkg.sv @@
// Shared types, constants and helper functions for the bracket balance repair core.
package bbr_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] CHR_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CHR_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CHR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHR_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CHR_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [1:0] {
        CODE_PAREN  = 2'd0,
        CODE_SQUARE = 2'd1,
        CODE_CURLY  = 2'd2,
        CODE_SPARE  = 2'd3
    } t_code;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_FLUSH = 1'b1
    } t_state;

    localparam logic ACT_TEXT  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Shift control for the stack cells.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_op;

    function automatic logic is_opener(input logic [7:0] b);
        return (b == CHR_OPEN_PAREN) || (b == CHR_OPEN_SQUARE) || (b == CHR_OPEN_CURLY);
    endfunction

    function automatic logic is_closer(input logic [7:0] b);
        return (b == CHR_CLOSE_PAREN) || (b == CHR_CLOSE_SQUARE) || (b == CHR_CLOSE_CURLY);
    endfunction

    function automatic t_code code_of(input logic [7:0] b);
        t_code c;
        c = CODE_CURLY;
        if (b == CHR_OPEN_PAREN) begin
            c = CODE_PAREN;
        end else if (b == CHR_OPEN_SQUARE) begin
            c = CODE_SQUARE;
        end
        return c;
    endfunction

    function automatic logic [7:0] closer_of(input t_code c);
        logic [7:0] r;
        unique case (c)
            CODE_PAREN:  r = CHR_CLOSE_PAREN;
            CODE_SQUARE: r = CHR_CLOSE_SQUARE;
            CODE_CURLY:  r = CHR_CLOSE_CURLY;
            default:     r = CHR_CLOSE_PAREN;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/bbr_cell.sv @@
// One stack cell: holds a bracket code and shifts with its neighbors on push or pop.
module bbr_cell (
    input  logic              i_clk,
    input  bbr_pkg::t_stack_op i_op,
    input  bbr_pkg::t_code    i_from_above,
    input  bbr_pkg::t_code    i_from_below,
    output bbr_pkg::t_code    o_code
);
    import bbr_pkg::*;

    t_code r_code;

    // Push moves entries deeper, pop moves them toward the top.
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_code <= i_from_above;
        end else if (i_op.pop) begin
            r_code <= i_from_below;
        end
    end

    assign o_code = r_code;

endmodule

@@ hdl/bracket_balance_repair_core.sv @@
// Bracket balance repair: a text byte gives at most one result; a flush emits a closer per open bracket.
// Text results are registered in the output register; flush results come from the FLUSH state,
// one per cycle while the output is free, and the last of them has o_last set.
// Throughput: one text byte per cycle while the output is free; a flush holds input until the stack is empty.
// The stack is a row of shifting cells, top in cell 0, so a push or pop shifts all cells together.
// Reset (synchronous, active low) empties the stack count, clears overflow and the output valid flag.
module bracket_balance_repair_core #(
    parameter int STACK_DEPTH = bbr_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_overflowed
);
    import bbr_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    t_stack_op     stack_op;
    t_code         push_code;
    t_code         cell_code [STACK_DEPTH];
    logic          out_free;
    logic          accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign push_code  = code_of(i_data_byte);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_FLUSH) && (r_count != '0)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free && (r_count == ONE)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and result
    always_comb begin
        stack_op    = '0;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_TEXT)) begin
                    if (is_opener(i_data_byte)) begin
                        if (r_count < FULL) begin
                            stack_op.push = 1'b1;
                            n_count       = r_count + ONE;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_out_valid = 1'b1;
                        n_out_byte  = i_data_byte;
                    end else if (is_closer(i_data_byte)) begin
                        // Drop a closer with nothing open.
                        if (r_count != '0) begin
                            stack_op.pop = 1'b1;
                            n_count      = r_count - ONE;
                            n_out_valid  = 1'b1;
                            n_out_byte   = closer_of(cell_code[0]);
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_byte  = i_data_byte;
                    end
                    n_out_last = 1'b1;
                    n_out_ovf  = n_ovf;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    stack_op.pop = 1'b1;
                    n_count      = r_count - ONE;
                    n_out_valid  = 1'b1;
                    n_out_byte   = closer_of(cell_code[0]);
                    n_out_last   = (r_count == ONE);
                    n_out_ovf    = r_ovf;
                end
            end
            default: begin
                stack_op = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_code above;
        t_code below;
        if (g == 0) begin : g_top
            assign above = push_code;
        end else begin : g_mid
            assign above = cell_code[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign below = CODE_PAREN;
        end else begin : g_inner
            assign below = cell_code[g+1];
        end
        bbr_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (stack_op),
            .i_from_above (above),
            .i_from_below (below),
            .o_code       (cell_code[g])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_last       = r_out_last;
    assign o_overflowed = r_out_ovf;

endmodule
